// ===== rtl/kvcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// kvcsa_pkg
// Shared types and constants of the kv cache scatter address generator.
// ----------------------------------------------------------------------------
package kvcsa_pkg;

   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int SLOT_WIDTH       = 6;
   localparam int POS_WIDTH        = 32;
   localparam int LEN_WIDTH        = 16;
   localparam int BATCH_REG_WIDTH  = 7;
   localparam int PREFIX_REG_WIDTH = 13;
   localparam int PREFIX_CNT_WIDTH = 12;

   localparam logic [PREFIX_REG_WIDTH-1:0] MAX_PREFIX = 13'd4096;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIRCULAR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATCH      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PREFIX     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CACHE_LEN  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPDATE_LEN = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLICE      = 3'd5;

   typedef logic [LEN_WIDTH-1:0]        len_type;
   typedef logic signed [POS_WIDTH-1:0] pos_type;

   typedef struct packed {
      logic    start;
      pos_type position;
      len_type step;
      len_type modulus;
   } mod_req_type;

endpackage

// ===== rtl/kvcsa_if.sv =====
// ----------------------------------------------------------------------------
// kvcsa channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kvcsa_req_if import kvcsa_pkg::*; #(
   parameter int DATA_WIDTH = 64
) ();
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [SLOT_WIDTH-1:0] batch_slot;
   pos_type               write_position;
   logic [DATA_WIDTH-1:0] element_data;

   modport source (output valid, mode, batch_slot, write_position, element_data,
                   input ready);
   modport sink   (input valid, mode, batch_slot, write_position, element_data,
                   output ready);
endinterface

interface kvcsa_rsp_if import kvcsa_pkg::*; #(
   parameter int DATA_WIDTH = 64,
   parameter int ADDR_WIDTH = 50
) ();
   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] cache_address;
   logic [DATA_WIDTH-1:0] write_data;
   logic                  index_error;
   logic                  last;

   modport source (output valid, cache_address, write_data, index_error, last,
                   input ready);
   modport sink   (input valid, cache_address, write_data, index_error, last,
                   output ready);
endinterface

// ===== rtl/kv_cache_scatter_address.sv =====
// ----------------------------------------------------------------------------
// kv_cache_scatter_address
// Address generator for an in-place kv cache scatter: per-batch start table
// in a synchronous memory, element counters, and a staged address multiply.
// ----------------------------------------------------------------------------
// an update reads its start position from the table, is reduced if needed, and goes through
//   the multiply states to the output register; the 32-step serial remainder unit reduces it
//   for the first element of a row or after a register or table write, not in linear mode or
//   for later elements of a row. Requests are taken only in idle, so a new update waits for
//   the previous one to reach the output register; a load is taken without leaving idle.
// reset: a clearing pass zeroes the table; transactions wait for it, register writes do not
module kv_cache_scatter_address import kvcsa_pkg::*; #(
   parameter int MAX_BATCH  = 64,
   parameter int DATA_WIDTH = 64,
   parameter int ADDR_WIDTH = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   kvcsa_req_if.sink                  req_chan,
   kvcsa_rsp_if.source                rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int BW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int NBW = (BW + 1 > BATCH_REG_WIDTH) ? BW + 1 : BATCH_REG_WIDTH;
   localparam int SW  = (BW > SLOT_WIDTH) ? BW : SLOT_WIDTH;
   localparam int PW  = BW + PREFIX_REG_WIDTH;
   localparam int QW  = PW + LEN_WIDTH + 1;
   localparam int AFW = (QW + LEN_WIDTH + 1 > ADDR_WIDTH) ? QW + LEN_WIDTH + 1 : ADDR_WIDTH;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_MUL1  = 3'd4;
   localparam logic [2:0] ST_MUL2  = 3'd5;
   localparam logic [2:0] ST_MUL3  = 3'd6;

   // configuration registers
   logic                        circular_ff;
   logic [BATCH_REG_WIDTH-1:0]  batch_reg_ff;
   logic [PREFIX_REG_WIDTH-1:0] prefix_reg_ff;
   len_type                     cache_len_ff;
   len_type                     update_len_ff;
   len_type                     slice_ff;

   // control
   logic [2:0]                  st_ff, st_in;
   logic [BW-1:0]               clr_cnt_ff, clr_cnt_in;
   len_type                     elem_ff, elem_in;
   len_type                     step_ff, step_in;
   logic [PREFIX_CNT_WIDTH-1:0] prefix_cnt_ff, prefix_cnt_in;
   logic [BW-1:0]               batch_now_ff, batch_now_in;
   logic                        wrap_valid_ff, wrap_valid_in;
   len_type                     wrap_idx_ff, wrap_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [DATA_WIDTH-1:0]       data_ff, data_in;
   len_type                     cur_idx_ff, cur_idx_in;
   logic                        err_ff, err_in;
   logic [PW-1:0]               p_ff, p_in;
   logic [QW-1:0]               q_ff, q_in;
   logic [ADDR_WIDTH-1:0]       addr_ff, addr_in;
   logic [DATA_WIDTH-1:0]       wdata_ff, wdata_in;
   logic                        ierr_ff, ierr_in;
   logic                        last_ff, last_in;

   // limits after zero and oversize folding
   logic [NBW-1:0]              nb;
   logic [PREFIX_REG_WIDTH-1:0] np;
   len_type                     ml, ul, sl;

   logic                        req_accept, load_accept, upd_accept;
   logic                        slot_ok;
   logic [SW-1:0]               slot_ext;
   logic                        out_free, advance;
   logic [LEN_WIDTH:0]          elem_inc, step_inc, idx_inc;
   logic [PREFIX_REG_WIDTH-1:0] pre_inc;
   logic [NBW-1:0]              bat_inc;
   logic                        elem_wrap, step_wrap, pre_wrap, bat_wrap;
   logic [POS_WIDTH:0]          sum;
   logic [AFW-1:0]              addr_full;

   logic                        ram_we;
   logic [BW-1:0]               ram_waddr;
   pos_type                     ram_wdata, ram_rdata;
   mod_req_type                 mod_req;
   logic                        mod_done;
   len_type                     mod_result;

   kvcsa_start_ram #(
      .DEPTH      (MAX_BATCH),
      .INDEX_BITS (BW)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (batch_now_ff),
      .rd_data (ram_rdata)
   );

   kvcsa_mod_unit u_mod_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (mod_req),
      .done   (mod_done),
      .result (mod_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         circular_ff   <= 1'b0;
         batch_reg_ff  <= BATCH_REG_WIDTH'(1);
         prefix_reg_ff <= PREFIX_REG_WIDTH'(1);
         cache_len_ff  <= LEN_WIDTH'(1);
         update_len_ff <= LEN_WIDTH'(1);
         slice_ff      <= LEN_WIDTH'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CIRCULAR:   circular_ff   <= csr_write_data[0];
            CSR_BATCH:      batch_reg_ff  <= csr_write_data[BATCH_REG_WIDTH-1:0];
            CSR_PREFIX:     prefix_reg_ff <= csr_write_data[PREFIX_REG_WIDTH-1:0];
            CSR_CACHE_LEN:  cache_len_ff  <= csr_write_data[LEN_WIDTH-1:0];
            CSR_UPDATE_LEN: update_len_ff <= csr_write_data[LEN_WIDTH-1:0];
            CSR_SLICE:      slice_ff      <= csr_write_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (batch_reg_ff == '0) begin
         nb = NBW'(1);
      end else if (NBW'(batch_reg_ff) > NBW'(MAX_BATCH)) begin
         nb = NBW'(MAX_BATCH);
      end else begin
         nb = NBW'(batch_reg_ff);
      end
      if (prefix_reg_ff == '0) begin
         np = PREFIX_REG_WIDTH'(1);
      end else if (prefix_reg_ff > MAX_PREFIX) begin
         np = MAX_PREFIX;
      end else begin
         np = prefix_reg_ff;
      end
      ml = (cache_len_ff == '0)  ? LEN_WIDTH'(1) : cache_len_ff;
      ul = (update_len_ff == '0) ? LEN_WIDTH'(1) : update_len_ff;
      sl = (slice_ff == '0)      ? LEN_WIDTH'(1) : slice_ff;
   end

   assign req_chan.ready = (st_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign load_accept    = req_accept && !req_chan.mode;
   assign upd_accept     = req_accept && req_chan.mode;
   assign slot_ok        = ({26'b0, req_chan.batch_slot} < 32'(MAX_BATCH));
   assign slot_ext       = SW'(req_chan.batch_slot);

   // table writes: clearing pass, else load transactions
   always_comb begin
      if (st_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = load_accept && slot_ok;
         ram_waddr = slot_ext[BW-1:0];
         ram_wdata = req_chan.write_position;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = (st_ff == ST_MUL3) && out_free;

   assign elem_inc  = {1'b0, elem_ff} + 1'b1;
   assign step_inc  = {1'b0, step_ff} + 1'b1;
   assign pre_inc   = {1'b0, prefix_cnt_ff} + 1'b1;
   assign bat_inc   = NBW'(batch_now_ff) + NBW'(1);
   assign idx_inc   = {1'b0, cur_idx_ff} + 1'b1;
   assign elem_wrap = elem_inc >= {1'b0, sl};
   assign step_wrap = step_inc >= {1'b0, ul};
   assign pre_wrap  = pre_inc >= np;
   assign bat_wrap  = bat_inc >= nb;

   assign sum = {ram_rdata[POS_WIDTH-1], ram_rdata}
              + {{(POS_WIDTH+1-LEN_WIDTH){1'b0}}, step_ff};

   assign addr_full = AFW'(q_ff) * AFW'(sl) + AFW'(elem_ff);

   always_comb begin
      st_in         = st_ff;
      clr_cnt_in    = clr_cnt_ff;
      elem_in       = elem_ff;
      step_in       = step_ff;
      prefix_cnt_in = prefix_cnt_ff;
      batch_now_in  = batch_now_ff;
      wrap_valid_in = wrap_valid_ff;
      wrap_idx_in   = wrap_idx_ff;
      data_in       = data_ff;
      cur_idx_in    = cur_idx_ff;
      err_in        = err_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      ierr_in       = ierr_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      mod_req       = '{start: 1'b0, position: ram_rdata, step: step_ff, modulus: ml};

      case (st_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BW'(MAX_BATCH - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (upd_accept) begin
               data_in = req_chan.element_data;
               st_in   = ST_READ;
            end
         end
         ST_READ: begin
            err_in = 1'b0;
            if (circular_ff) begin
               if (wrap_valid_ff) begin
                  cur_idx_in = wrap_idx_ff;
                  st_in      = ST_MUL1;
               end else begin
                  mod_req.start = 1'b1;
                  st_in         = ST_MOD;
               end
            end else begin
               err_in     = sum[POS_WIDTH] ||
                            (sum[POS_WIDTH-1:0] >= {{(POS_WIDTH-LEN_WIDTH){1'b0}}, ml});
               cur_idx_in = sum[LEN_WIDTH-1:0];
               st_in      = ST_MUL1;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               cur_idx_in = mod_result;
               st_in      = ST_MUL1;
            end
         end
         ST_MUL1: begin
            p_in  = PW'(batch_now_ff) * PW'(np) + PW'(prefix_cnt_ff);
            st_in = ST_MUL2;
         end
         ST_MUL2: begin
            q_in  = QW'(p_ff) * QW'(ml) + QW'(cur_idx_ff);
            st_in = ST_MUL3;
         end
         ST_MUL3: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               addr_in      = err_ff ? '0 : addr_full[ADDR_WIDTH-1:0];
               wdata_in     = err_ff ? '0 : data_ff;
               ierr_in      = err_ff;
               last_in      = elem_wrap && step_wrap && pre_wrap && bat_wrap;
               elem_in      = elem_wrap ? '0 : elem_inc[LEN_WIDTH-1:0];
               if (elem_wrap) begin
                  step_in = step_wrap ? '0 : step_inc[LEN_WIDTH-1:0];
                  if (step_wrap) begin
                     prefix_cnt_in = pre_wrap ? '0 : pre_inc[PREFIX_CNT_WIDTH-1:0];
                     if (pre_wrap) begin
                        batch_now_in = bat_wrap ? '0 : bat_inc[BW-1:0];
                     end
                  end
               end
               // keep the wrapped index running within a row
               wrap_idx_in   = cur_idx_ff;
               wrap_valid_in = circular_ff && !(elem_wrap && step_wrap);
               if (elem_wrap) begin
                  wrap_idx_in = (idx_inc == {1'b0, ml}) ? '0 : idx_inc[LEN_WIDTH-1:0];
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable || load_accept) begin
         wrap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         elem_ff       <= '0;
         step_ff       <= '0;
         prefix_cnt_ff <= '0;
         batch_now_ff  <= '0;
         wrap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         clr_cnt_ff    <= clr_cnt_in;
         elem_ff       <= elem_in;
         step_ff       <= step_in;
         prefix_cnt_ff <= prefix_cnt_in;
         batch_now_ff  <= batch_now_in;
         wrap_valid_ff <= wrap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wrap_idx_ff <= wrap_idx_in;
      data_ff     <= data_in;
      cur_idx_ff  <= cur_idx_in;
      err_ff      <= err_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      ierr_ff     <= ierr_in;
      last_ff     <= last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cache_address = addr_ff;
   assign rsp_chan.write_data    = wdata_ff;
   assign rsp_chan.index_error   = ierr_ff;
   assign rsp_chan.last          = last_ff;

   // reset always starts the clearing pass
   assert property (@(posedge clock) reset |=> st_ff == ST_CLEAR)
      else $error("clearing pass not started after reset");

   // the remainder unit only reports while it is being waited on
   assert property (@(posedge clock) disable iff (reset) mod_done |-> st_ff == ST_MOD)
      else $error("remainder result outside its wait state");

   // a cached wrapped index always lies inside the cache length
   assert property (@(posedge clock) disable iff (reset)
                    wrap_valid_ff |-> (wrap_idx_ff < ml) && circular_ff)
      else $error("cached wrapped index out of range");

   // a finished address is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("result lost on the way to the output register");

endmodule

// ===== rtl/kvcsa_start_ram.sv =====
// ----------------------------------------------------------------------------
// kvcsa_start_ram
// Per-batch write position store, one write and one registered read port.
// ----------------------------------------------------------------------------
module kvcsa_start_ram import kvcsa_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int INDEX_BITS = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [INDEX_BITS-1:0] wr_addr,
   input  pos_type               wr_data,
   input  logic [INDEX_BITS-1:0] rd_addr,
   output pos_type               rd_data
);

   pos_type mem [DEPTH];
   pos_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kvcsa_mod_unit.sv =====
// ----------------------------------------------------------------------------
// kvcsa_mod_unit
// Bit-serial reduction of a signed sequence index into 0..modulus-1.
// ----------------------------------------------------------------------------
module kvcsa_mod_unit import kvcsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output logic        done,
   output len_type     result
);

   localparam int MAG_WIDTH = POS_WIDTH;
   localparam int CW        = $clog2(MAG_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   len_type              rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] dv_ff, dv_in;
   logic                 neg_ff, neg_in;
   len_type              modulus_ff, modulus_in;

   logic [POS_WIDTH:0]   sum;
   logic [POS_WIDTH:0]   mag;
   logic [LEN_WIDTH:0]   trial;

   always_comb begin
      sum        = {req.position[POS_WIDTH-1], req.position}
                 + {{(POS_WIDTH+1-LEN_WIDTH){1'b0}}, req.step};
      mag        = sum[POS_WIDTH] ? (~sum + 1'b1) : sum;
      trial      = {rem_ff, dv_ff[MAG_WIDTH-1]};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dv_in      = dv_ff;
      neg_in     = neg_ff;
      modulus_in = modulus_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         dv_in      = mag[MAG_WIDTH-1:0];
         neg_in     = sum[POS_WIDTH];
         modulus_in = req.modulus;
      end else if (busy_ff) begin
         // restoring step, remainder never exceeds the modulus
         if (trial >= {1'b0, modulus_ff}) begin
            rem_in = LEN_WIDTH'(trial - {1'b0, modulus_ff});
         end else begin
            rem_in = trial[LEN_WIDTH-1:0];
         end
         dv_in  = {dv_ff[MAG_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MAG_WIDTH-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      dv_ff      <= dv_in;
      neg_ff     <= neg_in;
      modulus_ff <= modulus_in;
   end

   // negative values fold back from the top
   assign done   = done_ff;
   assign result = (neg_ff && (rem_ff != '0)) ? (modulus_ff - rem_ff) : rem_ff;

endmodule

// ===== tb/sv/tb_kv_cache_scatter_address.sv =====
// ----------------------------------------------------------------------------
// tb_kv_cache_scatter_address
// Self-checking bench for the kv cache scatter address generator. Position
// loads and update elements go in over the request channel with random
// gaps, the response channel stalls at random, and each returned cache
// write is checked field by field against a shadow of the block's table,
// counters and registers. Directed cases cover the register extremes, linear
// bounds errors, circular wrap; random tensor shapes and far counters follow.
// ----------------------------------------------------------------------------
module tb_kv_cache_scatter_address;
   import kvcsa_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int DATA_BITS     = 64;
   localparam int ADDR_BITS     = 50;
   localparam int SETTLE_CYCLES = 48;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 440;
   localparam int MAX_REPORTS   = 60;

   typedef enum logic {MODE_LOAD = 1'b0, MODE_UPDATE = 1'b1} req_mode_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] data;
      logic                 index_error;
      logic                 last;
   } cache_write_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   kvcsa_req_if #(.DATA_WIDTH(DATA_BITS)) req_bus ();
   kvcsa_rsp_if #(.DATA_WIDTH(DATA_BITS), .ADDR_WIDTH(ADDR_BITS)) rsp_bus ();

   kv_cache_scatter_address #(
      .MAX_BATCH (TABLE_DEPTH),
      .DATA_WIDTH(DATA_BITS),
      .ADDR_WIDTH(ADDR_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_bus),
      .rsp_chan        (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // shadow registers
   logic                        cfg_circular   = 1'b0;
   logic [BATCH_REG_WIDTH-1:0]  cfg_batches    = 1;
   logic [PREFIX_REG_WIDTH-1:0] cfg_prefix     = 1;
   logic [LEN_WIDTH-1:0]        cfg_cache_len  = 1;
   logic [LEN_WIDTH-1:0]        cfg_update_len = 1;
   logic [LEN_WIDTH-1:0]        cfg_slice      = 1;

   // shadow table and element counters
   pos_type     start_pos [TABLE_DEPTH];
   int unsigned elem_at   = 0;
   int unsigned step_at   = 0;
   int unsigned prefix_at = 0;
   int unsigned batch_at  = 0;

   cache_write_type writes_due [$];
   int              error_count = 0;
   int              idle_cycles = 0;
   bit              steady      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void apply_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [CSR_DATA_WIDTH-1:0] value);
      case (idx)
         CSR_CIRCULAR:   cfg_circular   = value[0];
         CSR_BATCH:      cfg_batches    = value[BATCH_REG_WIDTH-1:0];
         CSR_PREFIX:     cfg_prefix     = value[PREFIX_REG_WIDTH-1:0];
         CSR_CACHE_LEN:  cfg_cache_len  = value[LEN_WIDTH-1:0];
         CSR_UPDATE_LEN: cfg_update_len = value[LEN_WIDTH-1:0];
         CSR_SLICE:      cfg_slice      = value[LEN_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   function automatic int unsigned cache_len_now();
      return (cfg_cache_len == 0) ? 1 : cfg_cache_len;
   endfunction

   // cache write caused by one update element; advances the counters
   function automatic cache_write_type next_cache_write(input logic [DATA_BITS-1:0] data);
      int unsigned       nb, np, ml, ul, sl;
      longint            idx;
      longint unsigned   row, addr;
      cache_write_type   w;
      nb = (cfg_batches == 0) ? 1 : cfg_batches;
      if (nb > TABLE_DEPTH) nb = TABLE_DEPTH;
      np = (cfg_prefix == 0) ? 1 : cfg_prefix;
      if (np > MAX_PREFIX) np = 32'(MAX_PREFIX);
      ml = cache_len_now();
      ul = (cfg_update_len == 0) ? 1 : cfg_update_len;
      sl = (cfg_slice == 0) ? 1 : cfg_slice;
      w = '0;

      idx = longint'(start_pos[batch_at % TABLE_DEPTH]) + longint'(step_at);
      if (cfg_circular) idx = ((idx % longint'(ml)) + longint'(ml)) % longint'(ml);
      w.index_error = !cfg_circular && (idx < 0 || idx >= longint'(ml));

      if (!w.index_error) begin
         row = 64'(batch_at);
         row = row * 64'(np) + 64'(prefix_at);
         addr = (row * 64'(ml) + unsigned'(idx)) * 64'(sl) + 64'(elem_at);
         w.address = addr[ADDR_BITS-1:0];
         w.data = data;
      end

      // counters left above a lowered limit are used once, then wrap
      elem_at++;
      if (elem_at >= sl) begin
         elem_at = 0;
         step_at++;
         if (step_at >= ul) begin
            step_at = 0;
            prefix_at++;
            if (prefix_at >= np) begin
               prefix_at = 0;
               batch_at++;
               if (batch_at >= nb) begin
                  batch_at = 0;
                  w.last = 1'b1;
               end
            end
         end
      end
      return w;
   endfunction

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady) return 0;
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [DATA_BITS-1:0] rand_data();
      return {$urandom, $urandom};
   endfunction

   function automatic pos_type pick_position(input int unsigned len);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return $urandom_range(0, len - 1);
      if (roll < 8) return $urandom_range(0, 2 * len + 6) - len - 3;
      return $urandom;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_REPORTS)
         $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input req_mode_type mode, input logic [SLOT_WIDTH-1:0] slot,
                            input pos_type position, input logic [DATA_BITS-1:0] data);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.mode           <= mode;
      req_bus.batch_slot     <= slot;
      req_bus.write_position <= position;
      req_bus.element_data   <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (mode == MODE_LOAD) begin
         if (slot < TABLE_DEPTH) start_pos[slot] = position;
      end else begin
         writes_due.push_back(next_cache_write(data));
      end
   endtask

   task automatic send_load(input logic [SLOT_WIDTH-1:0] slot, input pos_type position);
      send_item(MODE_LOAD, slot, position, rand_data());
   endtask

   task automatic send_update(input logic [DATA_BITS-1:0] data);
      send_item(MODE_UPDATE, SLOT_WIDTH'($urandom_range(0, 63)), $urandom, data);
   endtask

   // drop valid, let every cache write come back, then let the block go quiet
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      apply_csr(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(input int circular, input int batches, input int prefix,
                            input int cache_len, input int update_len, input int slice);
      write_reg(CSR_CIRCULAR, CSR_DATA_WIDTH'(circular));
      write_reg(CSR_BATCH, CSR_DATA_WIDTH'(batches));
      write_reg(CSR_PREFIX, CSR_DATA_WIDTH'(prefix));
      write_reg(CSR_CACHE_LEN, CSR_DATA_WIDTH'(cache_len));
      write_reg(CSR_UPDATE_LEN, CSR_DATA_WIDTH'(update_len));
      write_reg(CSR_SLICE, CSR_DATA_WIDTH'(slice));
   endtask

   task automatic test_reset_defaults();
      send_update('0);
      send_update('1);
      send_load(0, 1);
      send_update(rand_data());
      send_load(0, 0);
   endtask

   task automatic test_linear_bounds();
      wait_idle();
      set_shape(0, 2, 1, 4, 3, 1);
      // batch 0 runs off the end, batch 1 starts before the beginning
      send_load(0, 2);
      send_load(1, -1);
      repeat (6) send_update(rand_data());
   endtask

   task automatic test_circular_wrap();
      wait_idle();
      set_shape(1, 2, 1, 2, 3, 1);
      send_load(0, 32'sh8000_0000);
      send_load(1, 32'sh7fff_ffff);
      send_load(63, -1);
      repeat (6) send_update(rand_data());
   endtask

   task automatic test_size_register_limits();
      wait_idle();
      set_shape(0, 0, 0, 0, 0, 0);
      send_update(rand_data());
      wait_idle();
      set_shape(1, 127, 8191, 65535, 65535, 65535);
      send_load(SLOT_WIDTH'(batch_at), 32'sh7fff_ffff);
      repeat (2) send_update(rand_data());
   endtask

   task automatic test_random_tensors();
      int updates_sent, elements, circular, nb, np, cl, ul, sl;
      updates_sent = 0;
      while (updates_sent < RANDOM_ITEMS) begin
         wait_idle();
         steady   = ($urandom_range(0, 4) == 0);
         circular = $urandom_range(0, 1);
         nb = $urandom_range(1, 2);
         np = $urandom_range(1, 2);
         cl = $urandom_range(1, 9);
         ul = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cl + 4) : $urandom_range(1, cl);
         sl = $urandom_range(1, 2);
         elements = nb * np * ul * sl;
         if (elements > 64) elements = 64;
         if ($urandom_range(0, 7) == 0) begin
            // zero or oversized size registers, tensor left unfinished
            nb = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
            np = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
            cl = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 65535);
            ul = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535);
            sl = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535);
            elements = $urandom_range(4, 24);
         end
         set_shape(circular, nb, np, cl, ul, sl);
         send_load(SLOT_WIDTH'(batch_at), pick_position(cache_len_now()));
         for (int k = 0; k < 2; k++)
            send_load(SLOT_WIDTH'($urandom_range(0, 3)), pick_position(cache_len_now()));
         for (int e = 0; e < elements; e++) begin
            if ($urandom_range(0, 11) == 0)
               send_load(SLOT_WIDTH'($urandom_range(0, 63)), pick_position(cache_len_now()));
            send_update(rand_data());
            updates_sent++;
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_far_counters();
      wait_idle();
      set_shape(0, 64, 1, 1, 1, 1);
      while (batch_at != TABLE_DEPTH - 1) send_update(rand_data());
      // top batch with the widest sizes reaches the high address bits
      wait_idle();
      set_shape(1, 64, MAX_PREFIX, 65535, 65535, 65535);
      send_load(SLOT_WIDTH'(TABLE_DEPTH - 1), -1);
      repeat (3) send_update(rand_data());
      // shrink the limits, leaving the batch and element counters above them
      wait_idle();
      set_shape(1, 4, 1, 1, 1, 2);
      repeat (2) send_update(rand_data());
   endtask

   initial begin : rsp_ready_driver
      int span, gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         rsp_bus.ready <= 1'b1;
         span = $urandom_range(1, 12);
         repeat (span) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cache_write_type want;
      if (!reset && (rsp_bus.valid & rsp_bus.ready) === 1'b1) begin
         if (writes_due.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_bus.cache_address), '0);
         end else begin
            want = writes_due.pop_front();
            if (rsp_bus.cache_address !== want.address)
               report_mismatch("cache_address", 64'(rsp_bus.cache_address),
                               64'(want.address));
            if (rsp_bus.write_data !== want.data)
               report_mismatch("write_data", rsp_bus.write_data, want.data);
            if (rsp_bus.index_error !== want.index_error)
               report_mismatch("index_error", 64'(rsp_bus.index_error),
                               64'(want.index_error));
            if (rsp_bus.last !== want.last)
               report_mismatch("last", 64'(rsp_bus.last), 64'(want.last));
         end
      end
   end

   // nothing moving on either channel for too long means a hang
   always @(posedge clock) begin
      if ((req_bus.valid & req_bus.ready) === 1'b1 || (rsp_bus.valid & rsp_bus.ready) === 1'b1)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_kv_cache_scatter_address: errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) start_pos[i] = '0;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.mode           <= MODE_LOAD;
      req_bus.batch_slot     <= '0;
      req_bus.write_position <= '0;
      req_bus.element_data   <= '0;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_CIRCULAR;
      csr_write_data         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_linear_bounds();
      test_circular_wrap();
      test_size_register_limits();
      test_random_tensors();
      test_far_counters();

      wait_idle();
      if (error_count == 0)
         $display("tb_kv_cache_scatter_address: clean");
      else
         $display("tb_kv_cache_scatter_address: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/kvcsa_pkg.sv
rtl/kvcsa_if.sv
rtl/kvcsa_start_ram.sv
rtl/kvcsa_mod_unit.sv
rtl/kv_cache_scatter_address.sv
tb/sv/tb_kv_cache_scatter_address.sv
